// ===== hw/rtl/bcc_pkg.sv =====
// Shared register indexes and control types for the barycentric converter.
package bcc_pkg;

	localparam int unsigned CFG_ADDR_W = 3;

	// Configuration register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_A_X = 3'd0,
		REG_A_Y = 3'd1,
		REG_B_X = 3'd2,
		REG_B_Y = 3'd3,
		REG_C_X = 3'd4,
		REG_C_Y = 3'd5
	} reg_idx_t;

	// Per-item control flags that travel beside the divider lanes
	typedef struct packed {
		logic       cmd;
		logic       degen;
		logic [2:0] ovf;
		logic [2:0] neg;
		logic       sat;
	} bcc_flags_t;

endpackage

// ===== hw/rtl/bcc_front.sv =====
// Front end: edge vectors, cross products, divider operands and the weights-to-point path.
module bcc_front #(
	parameter int CW = 16,
	parameter int F  = 16
) (
	input  logic                       clk,
	input  logic [3:0]                 en,
	input  logic                       cmd,
	input  logic signed [CW-1:0]       point_x,
	input  logic signed [CW-1:0]       point_y,
	input  logic signed [F+3:0]        weight_in_a,
	input  logic signed [F+3:0]        weight_in_b,
	input  logic signed [F+3:0]        weight_in_c,
	input  logic signed [CW-1:0]       ax,
	input  logic signed [CW-1:0]       ay,
	input  logic signed [CW-1:0]       bx,
	input  logic signed [CW-1:0]       by,
	input  logic signed [CW-1:0]       cx,
	input  logic signed [CW-1:0]       cy,
	output bcc_pkg::bcc_flags_t        flags,
	output logic [2*CW+3+F+4:0]        num_a,
	output logic [2*CW+3+F+4:0]        num_b,
	output logic [2*CW+3+F+4:0]        num_c,
	output logic [2*CW+2:0]            den,
	output logic signed [CW-1:0]       rx,
	output logic signed [CW-1:0]       ry
);
	import bcc_pkg::*;

	localparam int WW = F + 4;
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int XW = PW + 1;
	localparam int NW = XW + WW + 1;
	localparam int SW = WW + CW + 2;
	localparam int MW = SW + 1 - F;
	localparam logic [MW-1:0] POS_LIM = MW'((64'd1 << (CW - 1)) - 64'd1);
	localparam logic [MW-1:0] NEG_LIM = MW'(64'd1 << (CW - 1));
	localparam logic [SW:0]   HALF    = (SW+1)'(64'd1 << (F - 1));

	// Stage 1: differences and weight products
	logic                   cmd_s1;
	logic signed [DW-1:0]   abx_s1, aby_s1, acx_s1, acy_s1, apx_s1, apy_s1;
	logic signed [DW-1:0]   cbx_s1, cby_s1, bpx_s1, bpy_s1;
	logic signed [WW+CW-1:0] pax_s1, pbx_s1, pcx_s1, pay_s1, pby_s1, pcy_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			cmd_s1 <= cmd;
			abx_s1 <= DW'(bx) - DW'(ax);
			aby_s1 <= DW'(by) - DW'(ay);
			acx_s1 <= DW'(cx) - DW'(ax);
			acy_s1 <= DW'(cy) - DW'(ay);
			apx_s1 <= DW'(point_x) - DW'(ax);
			apy_s1 <= DW'(point_y) - DW'(ay);
			cbx_s1 <= DW'(cx) - DW'(bx);
			cby_s1 <= DW'(cy) - DW'(by);
			bpx_s1 <= DW'(point_x) - DW'(bx);
			bpy_s1 <= DW'(point_y) - DW'(by);
			pax_s1 <= weight_in_a * ax;
			pbx_s1 <= weight_in_b * bx;
			pcx_s1 <= weight_in_c * cx;
			pay_s1 <= weight_in_a * ay;
			pby_s1 <= weight_in_b * by;
			pcy_s1 <= weight_in_c * cy;
		end
	end

	// Stage 2: cross product terms and weighted sums
	logic                 cmd_s2;
	logic signed [PW-1:0] d0_s2, d1_s2, a0_s2, a1_s2, b0_s2, b1_s2, c0_s2, c1_s2;
	logic signed [SW-1:0] sx_s2, sy_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			cmd_s2 <= cmd_s1;
			d0_s2  <= abx_s1 * acy_s1;
			d1_s2  <= aby_s1 * acx_s1;
			a0_s2  <= cbx_s1 * bpy_s1;
			a1_s2  <= cby_s1 * bpx_s1;
			b0_s2  <= apx_s1 * acy_s1;
			b1_s2  <= apy_s1 * acx_s1;
			c0_s2  <= abx_s1 * apy_s1;
			c1_s2  <= aby_s1 * apx_s1;
			sx_s2  <= SW'(pax_s1) + SW'(pbx_s1) + SW'(pcx_s1);
			sy_s2  <= SW'(pay_s1) + SW'(pby_s1) + SW'(pcy_s1);
		end
	end

	// Stage 3: finish cross products, round the sums
	logic                 cmd_s3;
	logic signed [XW-1:0] d_s3, na_s3, nb_s3, nc_s3;
	logic                 negx_s3, negy_s3;
	logic [MW-1:0]        mx_s3, my_s3;
	logic [SW-1:0]        magx, magy;
	logic [SW:0]          rndx, rndy;

	always_comb begin
		magx = sx_s2[SW-1] ? SW'(-sx_s2) : SW'(sx_s2);
		magy = sy_s2[SW-1] ? SW'(-sy_s2) : SW'(sy_s2);
		rndx = (SW+1)'(magx) + HALF;
		rndy = (SW+1)'(magy) + HALF;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			cmd_s3  <= cmd_s2;
			d_s3    <= XW'(d0_s2) - XW'(d1_s2);
			na_s3   <= XW'(a0_s2) - XW'(a1_s2);
			nb_s3   <= XW'(b0_s2) - XW'(b1_s2);
			nc_s3   <= XW'(c0_s2) - XW'(c1_s2);
			negx_s3 <= sx_s2[SW-1];
			negy_s3 <= sy_s2[SW-1];
			mx_s3   <= MW'(rndx >> F);
			my_s3   <= MW'(rndy >> F);
		end
	end

	// Stage 4: divider operands and overflow check, clamp the point
	logic [XW-1:0] md, mna, mnb, mnc;
	logic [NW-1:0] nma, nmb, nmc, lim;
	logic          satx, saty;
	logic signed [CW-1:0] cx_v, cy_v;

	always_comb begin
		md  = d_s3[XW-1]  ? XW'(-d_s3)  : XW'(d_s3);
		mna = na_s3[XW-1] ? XW'(-na_s3) : XW'(na_s3);
		mnb = nb_s3[XW-1] ? XW'(-nb_s3) : XW'(nb_s3);
		mnc = nc_s3[XW-1] ? XW'(-nc_s3) : XW'(nc_s3);
		nma = (NW'(mna) << F) + NW'(md >> 1);
		nmb = (NW'(mnb) << F) + NW'(md >> 1);
		nmc = (NW'(mnc) << F) + NW'(md >> 1);
		lim = NW'(md) << WW;
		satx = negx_s3 ? (mx_s3 > NEG_LIM) : (mx_s3 > POS_LIM);
		saty = negy_s3 ? (my_s3 > NEG_LIM) : (my_s3 > POS_LIM);
		if (satx)
			cx_v = negx_s3 ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		else
			cx_v = negx_s3 ? CW'(~mx_s3 + 1'b1) : CW'(mx_s3);
		if (saty)
			cy_v = negy_s3 ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		else
			cy_v = negy_s3 ? CW'(~my_s3 + 1'b1) : CW'(my_s3);
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			flags.cmd   <= cmd_s3;
			flags.degen <= (d_s3 == '0);
			flags.ovf   <= {nmc >= lim, nmb >= lim, nma >= lim};
			flags.neg   <= {nc_s3[XW-1] ^ d_s3[XW-1], nb_s3[XW-1] ^ d_s3[XW-1],
				na_s3[XW-1] ^ d_s3[XW-1]};
			flags.sat   <= satx | saty;
			num_a       <= nma;
			num_b       <= nmb;
			num_c       <= nmc;
			den         <= md;
			rx          <= cx_v;
			ry          <= cy_v;
		end
	end

endmodule

// ===== hw/rtl/bcc_div_lane.sv =====
// Restoring divider lane, one quotient bit per pipeline stage.
module bcc_div_lane #(
	parameter int XW = 35,
	parameter int WW = 20
) (
	input  logic                clk,
	input  logic [WW-1:0]       en,
	input  logic [XW+WW:0]      num,
	input  logic [XW-1:0]       den,
	output logic [WW-1:0]       quo
);
	localparam int NW = XW + WW + 1;

	logic [NW-1:0] rem_sk [WW];
	logic [XW-1:0] den_sk [WW];
	logic [WW-1:0] quo_sk [WW];

	for (genvar j = 0; j < WW; j++) begin : g_stage
		logic [NW-1:0] rem_prev;
		logic [XW-1:0] den_prev;
		logic [WW-1:0] quo_prev;
		logic [NW:0]   trial;
		logic          take;

		if (j == 0) begin : g_first
			assign rem_prev = num;
			assign den_prev = den;
			assign quo_prev = '0;
		end else begin : g_next
			assign rem_prev = rem_sk[j-1];
			assign den_prev = den_sk[j-1];
			assign quo_prev = quo_sk[j-1];
		end

		// Trial subtract of the divisor at this bit weight
		assign trial = {1'b0, rem_prev} - ((NW+1)'(den_prev) << (WW - 1 - j));
		assign take  = ~trial[NW];

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_sk[j] <= take ? trial[NW-1:0] : rem_prev;
				den_sk[j] <= den_prev;
				quo_sk[j] <= {quo_prev[WW-2:0], take};
			end
		end
	end

	assign quo = quo_sk[WW-1];

endmodule

// ===== hw/rtl/barycentric_coordinate_converter_core.sv =====
// Top level of the barycentric coordinate converter: config, stall control, final clamp.
//
// channel | direction | tdata (low bit up)                        | tuser
// s_axis  | in        | point_x, point_y, weight_in_a/b/c, pad    | cmd
// m_axis  | out       | weight_out_a/b/c, result_x, result_y, pad | degenerate, saturated
// cfg     | in        | cfg_we, cfg_addr (register index), cfg_wdata
//
// One item per cycle sustained while m_axis_tready is high. The pipeline has four front stages,
// one divider stage per weight bit (FRAC_BITS + 4), then the output register.
// Reset clears valid bits and loads the vertex registers; payload is not reset.
// Each stage advances when empty or when the stage after it advances, so bubbles
// close up under output stall and nothing is dropped or repeated.
module barycentric_coordinate_converter_core #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// point_x, point_y, weight_in_a, weight_in_b, weight_in_c, zero pad
	input  logic [((2*COORD_WIDTH+3*(FRAC_BITS+4)+7)/8)*8-1:0] s_axis_tdata,
	// cmd
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// weight_out_a, weight_out_b, weight_out_c, result_x, result_y, zero pad
	output logic [((2*COORD_WIDTH+3*(FRAC_BITS+4)+7)/8)*8-1:0] m_axis_tdata,
	// degenerate, saturated
	output logic [1:0] m_axis_tuser,
	input  logic cfg_we,
	input  logic [bcc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [COORD_WIDTH-1:0] cfg_wdata
);
	import bcc_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int WW = F + 4;
	localparam int XW = 2 * (CW + 1) + 1;
	localparam int NW = XW + WW + 1;
	localparam int TW = ((2*CW + 3*WW + 7) / 8) * 8;
	localparam int L  = WW + 5;
	localparam logic [WW-1:0] W_POS = {1'b0, {(WW-1){1'b1}}};
	localparam logic [WW-1:0] W_NEG = {1'b1, {(WW-1){1'b0}}};

	typedef struct packed {
		bcc_flags_t          flags;
		logic signed [CW-1:0] rx;
		logic signed [CW-1:0] ry;
	} side_t;

	// Vertex registers
	logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0;
			ay_q <= '0;
			bx_q <= CW'(256);
			by_q <= '0;
			cx_q <= '0;
			cy_q <= CW'(256);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_A_X: ax_q <= cfg_wdata;
				REG_A_Y: ay_q <= cfg_wdata;
				REG_B_X: bx_q <= cfg_wdata;
				REG_B_Y: by_q <= cfg_wdata;
				REG_C_X: cx_q <= cfg_wdata;
				REG_C_Y: cy_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Stage valid bits and advance enables
	logic [L:1] v_q;
	logic [L:1] en;

	always_comb begin
		en[L] = ~v_q[L] | m_axis_tready;
		for (int k = L - 1; k >= 1; k--)
			en[k] = ~v_q[k] | en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1])
				v_q[1] <= s_axis_tvalid;
			for (int k = 2; k <= L; k++)
				if (en[k])
					v_q[k] <= v_q[k-1];
		end
	end

	assign s_axis_tready = en[1];
	assign m_axis_tvalid = v_q[L];

	// Front end
	bcc_flags_t           fr_flags;
	logic [NW-1:0]        num_a, num_b, num_c;
	logic [XW-1:0]        den;
	logic signed [CW-1:0] fr_rx, fr_ry;

	bcc_front #(.CW(CW), .F(F)) u_front (
		.clk         (clk),
		.en          (en[4:1]),
		.cmd         (s_axis_tuser),
		.point_x     (s_axis_tdata[CW-1:0]),
		.point_y     (s_axis_tdata[2*CW-1:CW]),
		.weight_in_a (s_axis_tdata[2*CW+WW-1:2*CW]),
		.weight_in_b (s_axis_tdata[2*CW+2*WW-1:2*CW+WW]),
		.weight_in_c (s_axis_tdata[2*CW+3*WW-1:2*CW+2*WW]),
		.ax          (ax_q),
		.ay          (ay_q),
		.bx          (bx_q),
		.by          (by_q),
		.cx          (cx_q),
		.cy          (cy_q),
		.flags       (fr_flags),
		.num_a       (num_a),
		.num_b       (num_b),
		.num_c       (num_c),
		.den         (den),
		.rx          (fr_rx),
		.ry          (fr_ry)
	);

	// Divider lanes, one per weight
	logic [WW-1:0] qa, qb, qc;

	bcc_div_lane #(.XW(XW), .WW(WW)) u_div_a (
		.clk (clk), .en (en[4+WW:5]), .num (num_a), .den (den), .quo (qa)
	);
	bcc_div_lane #(.XW(XW), .WW(WW)) u_div_b (
		.clk (clk), .en (en[4+WW:5]), .num (num_b), .den (den), .quo (qb)
	);
	bcc_div_lane #(.XW(XW), .WW(WW)) u_div_c (
		.clk (clk), .en (en[4+WW:5]), .num (num_c), .den (den), .quo (qc)
	);

	// Carry flags and point beside the divider
	side_t side_sk [WW];

	always_ff @(posedge clk) begin
		if (en[5])
			side_sk[0] <= side_t'{fr_flags, fr_rx, fr_ry};
		for (int j = 1; j < WW; j++)
			if (en[5+j])
				side_sk[j] <= side_sk[j-1];
	end

	// Final stage: sign, clamp and select
	side_t         sd;
	logic [WW-1:0] q [3];
	logic [WW-1:0] w [3];
	logic [2:0]    wsat;

	always_comb begin
		sd   = side_sk[WW-1];
		q[0] = qa;
		q[1] = qb;
		q[2] = qc;
		for (int i = 0; i < 3; i++) begin
			if (sd.flags.neg[i]) begin
				wsat[i] = sd.flags.ovf[i] | (q[i] > W_NEG);
				w[i]    = wsat[i] ? W_NEG : WW'(~q[i] + 1'b1);
			end else begin
				wsat[i] = sd.flags.ovf[i] | (q[i] > W_POS);
				w[i]    = wsat[i] ? W_POS : q[i];
			end
		end
	end

	logic [WW-1:0] wa_q, wb_q, wc_q;
	logic [CW-1:0] rx_q, ry_q;
	logic          degen_q, sat_q;

	always_ff @(posedge clk) begin
		if (en[L]) begin
			if (sd.flags.cmd) begin
				wa_q    <= '0;
				wb_q    <= '0;
				wc_q    <= '0;
				rx_q    <= sd.rx;
				ry_q    <= sd.ry;
				degen_q <= 1'b0;
				sat_q   <= sd.flags.sat;
			end else if (sd.flags.degen) begin
				wa_q    <= '0;
				wb_q    <= '0;
				wc_q    <= '0;
				rx_q    <= '0;
				ry_q    <= '0;
				degen_q <= 1'b1;
				sat_q   <= 1'b0;
			end else begin
				wa_q    <= w[0];
				wb_q    <= w[1];
				wc_q    <= w[2];
				rx_q    <= '0;
				ry_q    <= '0;
				degen_q <= 1'b0;
				sat_q   <= |wsat;
			end
		end
	end

	assign m_axis_tdata = TW'({ry_q, rx_q, wc_q, wb_q, wa_q});
	assign m_axis_tuser = {sat_q, degen_q};

	// An empty output register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_q[L] |-> s_axis_tready)
		else $error("input stalled with empty output stage");

	// An item in the last divider stage moves to the output when allowed
	a_last_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[L-1] && en[L] |=> v_q[L])
		else $error("item lost entering output stage");

	// Degenerate results carry zero weights and no saturation
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[3*WW-1:0] == '0 && !m_axis_tuser[1])
		else $error("degenerate result with nonzero weights");

endmodule
